[hw/rtl/crsc_pkg.sv]
// Shared types and constants of the column surface crossing scan.
// Used by the shared mul/div unit, the top level and the port checker.
package crsc_pkg;

    localparam int FRAC_W   = 17;
    localparam int DEN_W    = 24;
    localparam int Y_W      = 32;
    localparam int CFG_W    = 24;
    localparam int TDATA_IN_W  = 112;
    localparam int TDATA_OUT_W = 64;
    localparam int TUSER_OUT_W = 3;

    // magnitudes of the interpolation operands
    localparam int MAG_A_W   = Y_W;
    localparam int MAG_D_W   = DEN_W;
    localparam int PROD_W    = MAG_A_W + MAG_D_W;
    localparam int QUO_W     = PROD_W + 1;
    localparam int MUL_STEPS = MAG_D_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int SUM_W     = QUO_W + 2;

    localparam logic [FRAC_W-1:0] FRAC_THR_RST = 17'd32768;
    localparam logic [DEN_W-1:0]  DEN_THR_RST  = 24'd51200;
    localparam logic [Y_W-1:0]    Y_MAX        = 32'h7FFF_FFFF;
    localparam logic [Y_W-1:0]    Y_MIN        = 32'h8000_0000;
    localparam logic [1:0]        ROW_FULL     = 2'd2;

    localparam logic [0:0] REG_FRAC_THR = 1'b0;
    localparam logic [0:0] REG_DEN_THR  = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FRAC = 2'd1;
    localparam logic [1:0] KIND_DEN  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [MAG_A_W-1:0] mag_a;
        logic [MAG_D_W-1:0] mag_b;
        logic [MAG_D_W-1:0] mag_d;
    } t_md_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_md_stat;

endpackage

[hw/rtl/crsc_muldiv.sv]
// Shared iterative unit: round((a * b + d/2) / d) on magnitudes.
// Shift-add multiply, one bit a cycle, then restoring divide. Uses crsc_pkg.
module crsc_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crsc_pkg::t_md_req  i_req,
    output crsc_pkg::t_md_stat o_stat
);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_MUL  = 5'b00010,
        MD_PREP = 5'b00100,
        MD_DIV  = 5'b01000,
        MD_DONE = 5'b10000
    } t_md_state;

    t_md_state                       r_state, n_state;
    logic [crsc_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [crsc_pkg::PROD_W-1:0]     r_acc, n_acc;
    logic [crsc_pkg::MAG_A_W-1:0]    r_mcand, n_mcand;
    logic [crsc_pkg::MAG_D_W-1:0]    r_mplier, n_mplier;
    logic [crsc_pkg::MAG_D_W-1:0]    r_div, n_div;
    logic [crsc_pkg::MAG_D_W-1:0]    r_rem, n_rem;
    logic [crsc_pkg::QUO_W-1:0]      r_quo, n_quo;

    logic [crsc_pkg::MAG_D_W:0]      rem_sh;
    logic [crsc_pkg::MAG_D_W:0]      rem_diff;
    logic                            rem_ge;

    assign rem_sh   = {r_rem, r_quo[crsc_pkg::QUO_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_div    = r_div;
        n_rem    = r_rem;
        n_quo    = r_quo;
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_mcand  = i_req.mag_a;
                    n_mplier = i_req.mag_b;
                    n_div    = i_req.mag_d;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = MD_MUL;
                end
            end
            MD_MUL: begin
                n_acc = {r_acc[crsc_pkg::PROD_W-2:0], 1'b0}
                      + (r_mplier[crsc_pkg::MAG_D_W-1]
                         ? {{crsc_pkg::MAG_D_W{1'b0}}, r_mcand}
                         : {crsc_pkg::PROD_W{1'b0}});
                n_mplier = {r_mplier[crsc_pkg::MAG_D_W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == crsc_pkg::CNT_W'(crsc_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = MD_PREP;
                end
            end
            MD_PREP: begin
                n_quo = {1'b0, r_acc}
                      + crsc_pkg::QUO_W'(r_div[crsc_pkg::MAG_D_W-1:1]);
                n_rem   = '0;
                n_state = MD_DIV;
            end
            MD_DIV: begin
                n_rem = rem_ge ? rem_diff[crsc_pkg::MAG_D_W-1:0]
                               : rem_sh[crsc_pkg::MAG_D_W-1:0];
                n_quo = {r_quo[crsc_pkg::QUO_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == crsc_pkg::CNT_W'(crsc_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = MD_DONE;
                end
            end
            MD_DONE: begin
                n_state = MD_IDLE;
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
    end

    assign o_stat = '{done: (r_state == MD_DONE), quo: r_quo};

endmodule

[hw/rtl/column_surface_crossing_scan_core.sv]
// Top level: column scan, crossing test, saturation and output register.
// Uses crsc_pkg and the shared unit crsc_muldiv.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata, tlast (cell)
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata, tuser (column result)
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_wdata
//
// A cell is taken when s_axis_tvalid and s_axis_tready are both high. A crossing
// cell with a nonzero denominator holds s_axis_tready low after its transaction for
// 24 multiply steps, one rounding add, 57 divide steps, a done state and the final
// add with saturation. Reset is synchronous, active low, and restores the threshold
// defaults. s_axis_tready drops during that computation and while a result waits.
module column_surface_crossing_scan_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // volume_fraction [16:0], cell_density [40:17], cell_y [72:41], column_x [104:73]
    input  logic [crsc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // profile_x [31:0], surface_y [63:32]
    output logic [crsc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    // crossing_kind [1:0], flat_pair [2]
    output logic [crsc_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [crsc_pkg::CFG_W-1:0]          i_cfg_wdata
);

    typedef enum logic [2:0] {
        ST_SCAN = 3'b001,
        ST_CALC = 3'b010,
        ST_SUM  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [crsc_pkg::FRAC_W-1:0]     r_fth;
    logic [crsc_pkg::DEN_W-1:0]      r_dth;
    logic [1:0]                      r_row_cnt, n_row_cnt;
    logic [crsc_pkg::FRAC_W-1:0]     r_prev_frac, n_prev_frac;
    logic [crsc_pkg::DEN_W-1:0]      r_prev_den, n_prev_den;
    logic [crsc_pkg::Y_W-1:0]        r_prev_y, n_prev_y;
    logic                            r_found, n_found;
    logic [crsc_pkg::Y_W-1:0]        r_held_y, n_held_y;
    logic [1:0]                      r_held_kind, n_held_kind;
    logic                            r_held_flat, n_held_flat;
    logic                            r_pend_last, n_pend_last;
    logic [crsc_pkg::Y_W-1:0]        r_pend_x, n_pend_x;
    logic                            r_neg, n_neg;
    logic                            r_out_valid, n_out_valid;
    logic [crsc_pkg::Y_W-1:0]        r_out_x, n_out_x;
    logic [crsc_pkg::Y_W-1:0]        r_out_y, n_out_y;
    logic [1:0]                      r_out_kind, n_out_kind;
    logic                            r_out_flat, n_out_flat;

    logic [crsc_pkg::FRAC_W-1:0]     in_vf;
    logic [crsc_pkg::DEN_W-1:0]      in_dn;
    logic [crsc_pkg::Y_W-1:0]        in_y;
    logic [crsc_pkg::Y_W-1:0]        in_x;
    logic                            accept;
    logic                            hit_f, hit_d;
    logic [crsc_pkg::DEN_W-1:0]      t_sel, b_sel, thr_sel;
    logic [crsc_pkg::DEN_W:0]        den, num, den_abs, num_abs;
    logic [crsc_pkg::Y_W:0]          dy, dy_abs;
    logic [crsc_pkg::SUM_W-1:0]      q_ext, sq, yp_ext, sum;
    logic                            sat_hi, sat_lo;
    logic [crsc_pkg::Y_W-1:0]        sum_sat;
    logic                            clear_col;

    crsc_pkg::t_md_req               md_req;
    crsc_pkg::t_md_stat              md_stat;

    assign in_vf = s_axis_tdata[16:0];
    assign in_dn = s_axis_tdata[40:17];
    assign in_y  = s_axis_tdata[72:41];
    assign in_x  = s_axis_tdata[104:73];

    assign s_axis_tready = (r_state == ST_SCAN) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // crossing tests and interpolation operands
    assign hit_f   = (r_row_cnt == crsc_pkg::ROW_FULL) && (in_vf > r_fth);
    assign hit_d   = !hit_f && (r_row_cnt == crsc_pkg::ROW_FULL) && (in_dn < r_dth);
    assign t_sel   = hit_f ? crsc_pkg::DEN_W'(in_vf) : in_dn;
    assign b_sel   = hit_f ? crsc_pkg::DEN_W'(r_prev_frac) : r_prev_den;
    assign thr_sel = hit_f ? crsc_pkg::DEN_W'(r_fth) : r_dth;
    assign den     = {1'b0, t_sel} - {1'b0, b_sel};
    assign num     = {1'b0, thr_sel} - {1'b0, b_sel};
    assign den_abs = den[crsc_pkg::DEN_W] ? ('0 - den) : den;
    assign num_abs = num[crsc_pkg::DEN_W] ? ('0 - num) : num;
    assign dy      = {in_y[crsc_pkg::Y_W-1], in_y} - {r_prev_y[crsc_pkg::Y_W-1], r_prev_y};
    assign dy_abs  = dy[crsc_pkg::Y_W] ? ('0 - dy) : dy;

    // final add and saturation
    assign q_ext  = crsc_pkg::SUM_W'(md_stat.quo);
    assign sq     = r_neg ? ('0 - q_ext) : q_ext;
    assign yp_ext = {{(crsc_pkg::SUM_W - crsc_pkg::Y_W){r_prev_y[crsc_pkg::Y_W-1]}}, r_prev_y};
    assign sum    = yp_ext + sq;
    assign sat_hi = !sum[crsc_pkg::SUM_W-1]
                  && (sum[crsc_pkg::SUM_W-2:crsc_pkg::Y_W-1] != '0);
    assign sat_lo = sum[crsc_pkg::SUM_W-1]
                  && (sum[crsc_pkg::SUM_W-2:crsc_pkg::Y_W-1] != '1);
    assign sum_sat = sat_hi ? crsc_pkg::Y_MAX
                   : (sat_lo ? crsc_pkg::Y_MIN : sum[crsc_pkg::Y_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_prev_frac = r_prev_frac;
        n_prev_den  = r_prev_den;
        n_prev_y    = r_prev_y;
        n_found     = r_found;
        n_held_y    = r_held_y;
        n_held_kind = r_held_kind;
        n_held_flat = r_held_flat;
        n_pend_last = r_pend_last;
        n_pend_x    = r_pend_x;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_kind  = r_out_kind;
        n_out_flat  = r_out_flat;
        clear_col   = 1'b0;

        md_req.start = 1'b0;
        md_req.mag_a = dy_abs[crsc_pkg::MAG_A_W-1:0];
        md_req.mag_b = num_abs[crsc_pkg::MAG_D_W-1:0];
        md_req.mag_d = den_abs[crsc_pkg::MAG_D_W-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_SCAN: begin
                if (accept) begin
                    if (!r_found) begin
                        if (hit_f || hit_d) begin
                            n_found     = 1'b1;
                            n_held_kind = hit_f ? crsc_pkg::KIND_FRAC : crsc_pkg::KIND_DEN;
                            if (den == '0) begin
                                n_held_y    = in_y;
                                n_held_flat = 1'b1;
                            end else begin
                                n_held_flat  = 1'b0;
                                md_req.start = 1'b1;
                                n_pend_last  = s_axis_tlast;
                                n_pend_x     = in_x;
                                n_neg        = dy[crsc_pkg::Y_W] ^ num[crsc_pkg::DEN_W]
                                             ^ den[crsc_pkg::DEN_W];
                                n_state      = ST_CALC;
                            end
                        end else begin
                            n_prev_frac = in_vf;
                            n_prev_den  = in_dn;
                            n_prev_y    = in_y;
                            n_held_y    = in_y;
                            n_held_kind = crsc_pkg::KIND_NONE;
                            n_held_flat = 1'b0;
                            if (r_row_cnt != crsc_pkg::ROW_FULL) begin
                                n_row_cnt = r_row_cnt + 1'b1;
                            end
                        end
                    end
                    if (s_axis_tlast && !md_req.start) begin
                        n_out_valid = 1'b1;
                        n_out_x     = in_x;
                        n_out_y     = n_held_y;
                        n_out_kind  = n_held_kind;
                        n_out_flat  = n_held_flat;
                        clear_col   = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (md_stat.done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_held_y = sum_sat;
                if (r_pend_last) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pend_x;
                    n_out_y     = sum_sat;
                    n_out_kind  = r_held_kind;
                    n_out_flat  = r_held_flat;
                    clear_col   = 1'b1;
                end
                n_state = ST_SCAN;
            end
            default: begin
                n_state = ST_SCAN;
            end
        endcase

        if (clear_col) begin
            n_row_cnt = '0;
            n_found   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SCAN;
            r_fth       <= crsc_pkg::FRAC_THR_RST;
            r_dth       <= crsc_pkg::DEN_THR_RST;
            r_row_cnt   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_cnt   <= n_row_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    crsc_pkg::REG_FRAC_THR: r_fth <= i_cfg_wdata[crsc_pkg::FRAC_W-1:0];
                    crsc_pkg::REG_DEN_THR:  r_dth <= i_cfg_wdata[crsc_pkg::DEN_W-1:0];
                    default: begin
                        r_fth <= r_fth;
                    end
                endcase
            end
        end
        r_prev_frac <= n_prev_frac;
        r_prev_den  <= n_prev_den;
        r_prev_y    <= n_prev_y;
        r_held_y    <= n_held_y;
        r_held_kind <= n_held_kind;
        r_held_flat <= n_held_flat;
        r_pend_last <= n_pend_last;
        r_pend_x    <= n_pend_x;
        r_neg       <= n_neg;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_kind  <= n_out_kind;
        r_out_flat  <= n_out_flat;
    end

    crsc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_stat  (md_stat)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = {r_out_flat, r_out_kind};

endmodule

[hw/rtl/crsc_check.sv]
// Port checker for column_surface_crossing_scan_core, bound to the top level.
// Sees the ports only. Uses crsc_pkg.
module crsc_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tlast,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [crsc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input logic [crsc_pkg::TUSER_OUT_W-1:0]    m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result transaction changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("illegal crossing kind");

    a_flat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1:0] == crsc_pkg::KIND_FRAC
            || m_axis_tuser[1:0] == crsc_pkg::KIND_DEN)
        else $error("flat pair without a crossing");

    a_no_result_without_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready && s_axis_tlast)
            && !s_axis_tready |=> !m_axis_tvalid || !$past(s_axis_tready, 2)
            || $past(m_axis_tvalid, 2))
        else $error("result without a column end");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind column_surface_crossing_scan_core crsc_check u_crsc_check (.*);
